// ----- hw/rtl/blh2rgb_pkg.sv -----
package blh2rgb_pkg;

    localparam int unsigned NUM_STAGES = 6;

    localparam logic [7:0] BRIGHT_FLOOR = 8'd80;
    localparam logic [7:0] FULL_SCALE   = 8'd255;

    // six hue sectors, named by the channel that is full in each
    typedef enum logic [2:0] {
        SEC_RED_RISE_GREEN = 3'd0,
        SEC_GREEN_FALL_RED = 3'd1,
        SEC_GREEN_RISE_BLUE = 3'd2,
        SEC_BLUE_FALL_GREEN = 3'd3,
        SEC_BLUE_RISE_RED = 3'd4,
        SEC_RED_FALL_BLUE = 3'd5
    } sector_t;

endpackage

// ----- hw/rtl/breathing_led_hsv_to_rgb.sv -----
// channel  | ports                      | tdata fields, lowest bit up
// ---------+----------------------------+------------------------------------------------
// input    | s_tvalid s_tready s_tdata  | time_ms[15:0] hue[23:16] saturation[31:24]
//          |                            | phase_shift[39:32]
// result   | m_tvalid m_tready m_tdata  | red[7:0] green[15:8] blue[23:16]
//
// one word per clock sustained while m_tready is high, passing through six register stages
// (triangle/hue sector, squares, cube, brightness, three channel products, sector select)
// each stage holds its word while the next stage is full and stalled, so bubbles are
// squeezed out and s_tready drops only when all six stages hold data
// aresetn clears the stage valid bits only; the stage data registers are not reset
module breathing_led_hsv_to_rgb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // time_ms, hue, saturation, phase_shift
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red, green, blue
);
    import blh2rgb_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] rdy;

    // stage 0: phase, triangle fold, hue sector
    logic [7:0]  xd0_reg, xd0_next;
    sector_t     sec0_reg, sec0_next;
    logic [7:0]  frac0_reg, frac0_next;
    logic [7:0]  sat0_reg;
    // stage 1: square and saturation scaled fractions
    logic [7:0]  xd1_reg;
    logic [7:0]  x2_1_reg, x2_1_next;
    logic [7:0]  sf1_reg, sf1_next;
    logic [7:0]  st1_reg, st1_next;
    sector_t     sec1_reg;
    logic [7:0]  sat1_reg;
    // stage 2: cube and complements
    logic [7:0]  x2_2_reg;
    logic [7:0]  x3_2_reg, x3_2_next;
    logic [7:0]  pc2_reg, qc2_reg, tc2_reg;
    logic        grey2_reg;
    sector_t     sec2_reg;
    // stage 3: brightness
    logic [7:0]  v3_reg, v3_next;
    logic [7:0]  pc3_reg, qc3_reg, tc3_reg;
    logic        grey3_reg;
    sector_t     sec3_reg;
    // stage 4: channel products
    logic [7:0]  v4_reg;
    logic [7:0]  p4_reg, p4_next;
    logic [7:0]  q4_reg, q4_next;
    logic [7:0]  t4_reg, t4_next;
    logic        grey4_reg;
    sector_t     sec4_reg;
    // stage 5: output word
    logic [23:0] rgb5_reg, rgb5_next;

    // each stage takes a word when it is empty or its own word moves on
    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = rgb5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 0 logic
    logic [7:0]  phase0;
    logic [7:0]  fold0;
    logic [10:0] hue6;
    always_comb begin
        phase0 = s_tdata[11:4] + s_tdata[39:32];
        fold0  = phase0[7] ? (FULL_SCALE - phase0) : phase0;
        xd0_next = {fold0[6:0], 1'b0};
        hue6 = {1'b0, s_tdata[23:16], 2'b00} + {2'b00, s_tdata[23:16], 1'b0};
        sec0_next = sector_t'(hue6[10:8]);
        frac0_next = hue6[7:0];
    end

    // stage 1 logic
    logic [15:0] sq1, sfp1, stp1;
    always_comb begin
        sq1  = xd0_reg * xd0_reg;
        sfp1 = sat0_reg * frac0_reg;
        stp1 = sat0_reg * (FULL_SCALE - frac0_reg);
        x2_1_next = sq1[15:8];
        sf1_next  = sfp1[15:8];
        st1_next  = stp1[15:8];
    end

    // stage 2 logic
    logic [15:0] cube2;
    always_comb begin
        cube2 = x2_1_reg * xd1_reg;
        x3_2_next = cube2[15:8];
    end

    // stage 3 logic: (3*x2 - 2*x3)/2 + floor
    logic [9:0] three_x2, two_x3, diff3;
    always_comb begin
        three_x2 = {2'b00, x2_2_reg} + {1'b0, x2_2_reg, 1'b0};
        two_x3   = {1'b0, x3_2_reg, 1'b0};
        diff3    = three_x2 - two_x3;
        v3_next  = diff3[8:1] + BRIGHT_FLOOR;
    end

    // stage 4 logic
    logic [15:0] pp4, qp4, tp4;
    always_comb begin
        pp4 = v3_reg * pc3_reg;
        qp4 = v3_reg * qc3_reg;
        tp4 = v3_reg * tc3_reg;
        p4_next = pp4[15:8];
        q4_next = qp4[15:8];
        t4_next = tp4[15:8];
    end

    // stage 5 logic: words are packed blue, green, red from the top
    always_comb begin
        if (grey4_reg) begin
            rgb5_next = {v4_reg, v4_reg, v4_reg};
        end else begin
            case (sec4_reg)
                SEC_RED_RISE_GREEN:  rgb5_next = {p4_reg, t4_reg, v4_reg};
                SEC_GREEN_FALL_RED:  rgb5_next = {p4_reg, v4_reg, q4_reg};
                SEC_GREEN_RISE_BLUE: rgb5_next = {t4_reg, v4_reg, p4_reg};
                SEC_BLUE_FALL_GREEN: rgb5_next = {v4_reg, q4_reg, p4_reg};
                SEC_BLUE_RISE_RED:   rgb5_next = {v4_reg, p4_reg, t4_reg};
                default:             rgb5_next = {q4_reg, p4_reg, v4_reg};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            xd0_reg   <= xd0_next;
            sec0_reg  <= sec0_next;
            frac0_reg <= frac0_next;
            sat0_reg  <= s_tdata[31:24];
        end
        if (rdy[1]) begin
            xd1_reg  <= xd0_reg;
            x2_1_reg <= x2_1_next;
            sf1_reg  <= sf1_next;
            st1_reg  <= st1_next;
            sec1_reg <= sec0_reg;
            sat1_reg <= sat0_reg;
        end
        if (rdy[2]) begin
            x2_2_reg  <= x2_1_reg;
            x3_2_reg  <= x3_2_next;
            pc2_reg   <= FULL_SCALE - sat1_reg;
            qc2_reg   <= FULL_SCALE - sf1_reg;
            tc2_reg   <= FULL_SCALE - st1_reg;
            grey2_reg <= (sat1_reg == 8'd0);
            sec2_reg  <= sec1_reg;
        end
        if (rdy[3]) begin
            v3_reg    <= v3_next;
            pc3_reg   <= pc2_reg;
            qc3_reg   <= qc2_reg;
            tc3_reg   <= tc2_reg;
            grey3_reg <= grey2_reg;
            sec3_reg  <= sec2_reg;
        end
        if (rdy[4]) begin
            v4_reg    <= v3_reg;
            p4_reg    <= p4_next;
            q4_reg    <= q4_next;
            t4_reg    <= t4_next;
            grey4_reg <= grey3_reg;
            sec4_reg  <= sec3_reg;
        end
        if (rdy[5]) begin
            rgb5_reg <= rgb5_next;
        end
    end

`ifndef SYNTHESIS
    // input side backs up only when every stage holds a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // breathing level stays within the floor and the peak
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (v3_reg >= BRIGHT_FLOOR && v3_reg <= 8'd208))
        else $error("brightness out of range");

    // hue sector is one of six
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> (sec0_reg <= SEC_RED_FALL_BLUE))
        else $error("hue sector out of range");

    // a grey word has three equal channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && rdy[5] && grey4_reg) |=>
            (m_tdata[7:0] == m_tdata[15:8] && m_tdata[15:8] == m_tdata[23:16]))
        else $error("grey word has unequal channels");

    // nothing comes out right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
